[rtl/core/cnv3_pkg.sv]
// ----------------------------------------------------------------------------
// cnv3_pkg
// Shared types, register indexes and arithmetic helpers of the 3x3 filter.
// ----------------------------------------------------------------------------
package cnv3_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_MID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_BOT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd4;

  localparam int CFG_DATA_W = 48;
  localparam int COEF_W     = 16;
  localparam int SIZE_W     = 12;
  localparam int ROW_W      = 12;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 12'd480;

  // product of an unsigned pixel and a signed q8.8 coefficient
  localparam int PROD_W = 25;
  // sum of nine products
  localparam int SUM_W  = 28;
  localparam int QUO_W  = SUM_W - 8;

  // result queue
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = 3;
  localparam int OUT_CNT_W = 4;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    logic       action;
    logic [7:0] pixel_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       frame_end;
  } out_word_t;

  // control of the word leaving the line store stage
  typedef struct packed {
    logic       pix;    // pixel word, shifts the window
    logic       emit;   // gives a result
    logic       filt;   // result is the filtered sum
    logic       fend;   // last pixel of the frame
    logic       par;    // bank holding the older line
    logic [7:0] pixel;
  } stage_ctl_t;

  // pixel times coefficient
  function automatic prod_t mul_px(input logic [7:0] px, input logic signed [COEF_W-1:0] cf);
    return prod_t'(signed'({1'b0, px})) * prod_t'(cf);
  endfunction

  // round half to even on 8 fraction bits, clamp to 0..255
  function automatic logic [7:0] round_clamp(input sum_t s);
    logic [QUO_W-1:0] q;
    logic [7:0]       f;
    logic             up;
    logic [QUO_W:0]   qr;
    q  = s[SUM_W-1:8];
    f  = s[7:0];
    up = (f > 8'd128) || (f == 8'd128 && q[0]);
    qr = {1'b0, q} + {{QUO_W{1'b0}}, up};
    if (s <= sum_t'(0)) begin
      return 8'd0;
    end else if (qr > (QUO_W + 1)'(255)) begin
      return 8'hFF;
    end else begin
      return qr[7:0];
    end
  endfunction

endpackage

[rtl/core/cnv3_line_store.sv]
// ----------------------------------------------------------------------------
// cnv3_line_store
// Two line stores as one memory of byte pairs, one byte per row parity.
// ----------------------------------------------------------------------------
module cnv3_line_store #(
  parameter int MAX_WIDTH = 2048,
  parameter int AW        = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [AW-1:0] addr,
  input  logic [1:0]    we,
  input  logic [7:0]    wdata,
  output logic [15:0]   rdata
);

  logic [15:0] mem_r [MAX_WIDTH];
  logic [15:0] rdata_r;

  // read old contents, then write the new pixel into its bank
  always_ff @(posedge clk) begin
    if (adv) begin
      rdata_r <= mem_r[addr];
      if (we[0]) begin
        mem_r[addr][7:0] <= wdata;
      end
      if (we[1]) begin
        mem_r[addr][15:8] <= wdata;
      end
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/cnv3_seq.sv]
// ----------------------------------------------------------------------------
// cnv3_seq
// Input and output position counters, line store access and result decisions.
// ----------------------------------------------------------------------------
module cnv3_seq
  import cnv3_pkg::*;
#(
  parameter int MAX_WIDTH = 2048,
  parameter int CW        = $clog2(MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             acc,
  input  in_word_t         in_word,
  input  logic             restart,
  input  logic [CW-1:0]    w_last,
  input  logic [ROW_W-1:0] h_last,
  output logic [CW-1:0]    ls_addr,
  output logic [1:0]       ls_we,
  output logic [7:0]       ls_wdata,
  output stage_ctl_t       s1
);

  logic [CW-1:0]    in_col_r, in_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0]    out_col_r, out_col_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;
  stage_ctl_t       s1_r, s1_nxt;

  logic done, pix_go, drain_go, emit_pix, emit, border, fend;

  // decisions for the current word
  always_comb begin
    done     = in_row_r > h_last;
    pix_go   = acc && !in_word.action && !done;
    drain_go = acc && in_word.action && done;
    emit_pix = pix_go && (in_row_r != '0) && (in_col_r != '0 || in_row_r[ROW_W-1:1] != '0);
    emit     = emit_pix || drain_go;
    border   = (out_row_r == '0) || (out_row_r == h_last) ||
               (out_col_r == '0) || (out_col_r == w_last);
    fend     = (out_row_r == h_last) && (out_col_r == w_last);
  end

  // line store access: both banks at one column
  always_comb begin
    ls_addr  = pix_go ? in_col_r : out_col_r;
    ls_wdata = in_word.pixel_in;
    ls_we    = 2'b00;
    if (pix_go) begin
      ls_we[in_row_r[0]] = 1'b1;
    end
  end

  // counter advance
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (pix_go) begin
      if (in_col_r == w_last) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
    end
    if (emit) begin
      if (fend) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else if (out_col_r == w_last) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + 1'b1;
      end else begin
        out_col_nxt = out_col_r + 1'b1;
      end
    end
    if (restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end
  end

  // control of the word entering the filter
  always_comb begin
    s1_nxt.pix   = pix_go;
    s1_nxt.emit  = emit;
    s1_nxt.filt  = emit_pix && (in_col_r != '0) && !border;
    s1_nxt.fend  = emit && fend;
    s1_nxt.par   = pix_go ? in_row_r[0] : out_row_r[0];
    s1_nxt.pixel = in_word.pixel_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      s1_r      <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      if (adv) begin
        s1_r <= s1_nxt;
      end
    end
  end

  assign s1 = s1_r;

endmodule

[rtl/core/cnv3_filter.sv]
// ----------------------------------------------------------------------------
// cnv3_filter
// 3x3 window, nine parallel products, row sums and final rounding.
// ----------------------------------------------------------------------------
module cnv3_filter
  import cnv3_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  stage_ctl_t            s1,
  input  logic [15:0]           rdata,
  input  logic [CFG_DATA_W-1:0] coef_top,
  input  logic [CFG_DATA_W-1:0] coef_mid,
  input  logic [CFG_DATA_W-1:0] coef_bot,
  output logic                  push,
  output out_word_t             push_word,
  output logic [1:0]            busy
);

  logic [7:0] win_r   [3][3];
  logic [7:0] win_nxt [3][3];
  logic [7:0] col     [3];
  logic [CFG_DATA_W-1:0] coef_row [3];

  prod_t prod_r [3][3];
  sum_t  rsum_r [3];
  sum_t  total;

  logic       s2_emit_r, s2_filt_r, s2_fend_r;
  logic [7:0] s2_val_r;
  logic       s3_emit_r, s3_filt_r, s3_fend_r;
  logic [7:0] s3_val_r;

  assign coef_row[0] = coef_top;
  assign coef_row[1] = coef_mid;
  assign coef_row[2] = coef_bot;

  // new column: older line, previous line, incoming pixel
  always_comb begin
    col[0] = s1.par ? rdata[15:8] : rdata[7:0];
    col[1] = s1.par ? rdata[7:0] : rdata[15:8];
    col[2] = s1.pixel;
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
      win_nxt[i][2] = col[i];
    end
  end

  // window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (adv && s1.pix) begin
      win_r <= win_nxt;
    end
  end

  // products and row sums
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[i][j] <= mul_px(win_nxt[i][j], coef_row[i][COEF_W*j +: COEF_W]);
        end
        rsum_r[i] <= sum_t'(prod_r[i][0]) + sum_t'(prod_r[i][1]) + sum_t'(prod_r[i][2]);
      end
      // pass-through value: window center after the shift, or the stored byte on drain
      s2_val_r <= s1.pix ? win_r[1][2] : col[0];
      s3_val_r <= s2_val_r;
    end
  end

  // stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_emit_r <= 1'b0;
      s2_filt_r <= 1'b0;
      s2_fend_r <= 1'b0;
      s3_emit_r <= 1'b0;
      s3_filt_r <= 1'b0;
      s3_fend_r <= 1'b0;
    end else if (adv) begin
      s2_emit_r <= s1.emit;
      s2_filt_r <= s1.filt;
      s2_fend_r <= s1.fend;
      s3_emit_r <= s2_emit_r;
      s3_filt_r <= s2_filt_r;
      s3_fend_r <= s2_fend_r;
    end
  end

  // final sum and rounding
  always_comb begin
    total = rsum_r[0] + rsum_r[1] + rsum_r[2];
    push_word.pixel_out = s3_filt_r ? round_clamp(total) : s3_val_r;
    push_word.frame_end = s3_fend_r;
  end

  assign push = adv && s3_emit_r;
  assign busy = {1'b0, s2_emit_r} + {1'b0, s3_emit_r};

endmodule

[rtl/core/cnv3_out_fifo.sv]
// ----------------------------------------------------------------------------
// cnv3_out_fifo
// Small result queue that decouples the filter from the result channel.
// ----------------------------------------------------------------------------
module cnv3_out_fifo
  import cnv3_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  out_word_t            push_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word,
  output logic [OUT_CNT_W-1:0] count
);

  out_word_t              buf_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [OUT_CNT_W-1:0]   cnt_r;
  logic                   pop;

  assign pop = out_valid && !out_stall;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_word;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign out_valid = cnt_r != '0;
  assign out_word  = buf_r[rd_ptr_r];
  assign count     = cnt_r;

endmodule

[rtl/core/conv3x3_image_filter.sv]
// ----------------------------------------------------------------------------
// conv3x3_image_filter
// 3x3 convolution over a raster stream of 8-bit pixels with q8.8 kernel.
// ----------------------------------------------------------------------------
// pipeline: a taken word passes the line store read, products and row sums
//   registers before its result enters the queue; results lag pixels by one row + 1
// throughput: one word per cycle while in_stall is low, set by the single-port line store access
// reset: synchronous active low; clears counters, window and result queue,
//   loads kernel 0, width 640, height 480; line store content is not cleared
module conv3x3_image_filter
  import cnv3_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [CFG_DATA_W-1:0] coef_top_r, coef_mid_r, coef_bot_r;
  logic [SIZE_W-1:0]     img_width_r, img_height_r;
  logic [CW-1:0]         w_last;
  logic [ROW_W-1:0]      h_last;

  logic                 cfg_we, restart, adv, acc, push;
  logic [CW-1:0]        ls_addr;
  logic [1:0]           ls_we;
  logic [7:0]           ls_wdata;
  logic [15:0]          ls_rdata;
  stage_ctl_t           s1;
  out_word_t            push_word;
  logic [1:0]           busy;
  logic [OUT_CNT_W-1:0] q_count;
  logic [4:0]           pending;

  // configuration registers
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign restart   = cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_top_r   <= '0;
      coef_mid_r   <= '0;
      coef_bot_r   <= '0;
      img_width_r  <= WIDTH_RST;
      img_height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COEF_TOP: coef_top_r   <= cfg_data;
        CFG_COEF_MID: coef_mid_r   <= cfg_data;
        CFG_COEF_BOT: coef_bot_r   <= cfg_data;
        CFG_WIDTH:    img_width_r  <= cfg_data[SIZE_W-1:0];
        CFG_HEIGHT:   img_height_r <= cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // effective last column and last row
  always_comb begin
    if (img_width_r < 12'd3) begin
      w_last = CW'(2);
    end else if (int'(img_width_r) >= MAX_WIDTH) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(img_width_r - 12'd1);
    end
    if (img_height_r < 12'd3) begin
      h_last = ROW_W'(2);
    end else begin
      h_last = img_height_r - 12'd1;
    end
  end

  // the pipeline moves while the queue has room for every result in flight
  assign pending  = {1'b0, q_count} + {3'b000, busy} + {4'b0000, s1.emit};
  assign adv      = pending < 5'(OUT_DEPTH);
  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  cnv3_seq #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .acc      (acc),
    .in_word  (in_word),
    .restart  (restart),
    .w_last   (w_last),
    .h_last   (h_last),
    .ls_addr  (ls_addr),
    .ls_we    (ls_we),
    .ls_wdata (ls_wdata),
    .s1       (s1)
  );

  cnv3_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (CW)
  ) u_line_store (
    .clk   (clk),
    .adv   (adv),
    .addr  (ls_addr),
    .we    (ls_we),
    .wdata (ls_wdata),
    .rdata (ls_rdata)
  );

  cnv3_filter u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .s1        (s1),
    .rdata     (ls_rdata),
    .coef_top  (coef_top_r),
    .coef_mid  (coef_mid_r),
    .coef_bot  (coef_bot_r),
    .push      (push),
    .push_word (push_word),
    .busy      (busy)
  );

  cnv3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .count     (q_count)
  );

endmodule

[bench/tb_conv3x3_image_filter.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_conv3x3_image_filter
// Streams raster frames of pixels and drain words into the 3x3 filter and
// checks every result word against an in-bench filter of the same behavior:
// line stores, window, q8.8 kernel, round half to even, clamp and borders.
// Covers directed rounding cases, random frames under several idle mixes,
// back pressure and the extreme frame sizes.
// ----------------------------------------------------------------------------
module tb_conv3x3_image_filter;
  import cnv3_pkg::*;

  localparam int MAX_W = 2048;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam bit ACT_PIXEL = 1'b0;
  localparam bit ACT_DRAIN = 1'b1;
  localparam logic [15:0] STEP_COEFS [7] = '{16'h0000, 16'h0080, 16'hFF80, 16'h0100,
                                             16'hFF00, 16'h0180, 16'h0040};

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  conv3x3_image_filter uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // filter state mirrored in the bench
  logic [7:0] line_mem [0:2*MAX_W-1];
  logic [7:0] win [0:2][0:2];
  logic [47:0] kern [0:2];
  logic [SIZE_W-1:0] reg_width;
  logic [SIZE_W-1:0] reg_height;
  int unsigned col_in, row_in, col_out, row_out;

  in_word_t words_to_send [$];
  out_word_t pixels_due [$];
  out_word_t due_word;
  int unsigned bad_words = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_len = 0;
  bit hold_on = 1'b0;
  bit word_taken = 1'b0;
  bit frame_cut = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void flag_error(string msg);
    if (bad_words < 10) $display("[%0t] mismatch: %s", $time, msg);
    bad_words++;
  endfunction

  function automatic int unsigned eff_width();
    if (reg_width < 3) return 3;
    if (reg_width > MAX_W) return MAX_W;
    return 32'(reg_width);
  endfunction

  function automatic int unsigned eff_height();
    if (reg_height < 3) return 3;
    return 32'(reg_height);
  endfunction

  function automatic void restart_frame();
    col_in = 0;
    row_in = 0;
    col_out = 0;
    row_out = 0;
  endfunction

  // nine products, round half to even on 8 fraction bits, clamp to a byte
  function automatic logic [7:0] filter_center();
    int acc, q, f;
    int unsigned i, j;
    logic signed [15:0] cf;
    acc = 0;
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) begin
        cf = kern[i][16*j +: 16];
        acc += int'(win[i][j]) * int'(cf);
      end
    end
    if (acc <= 0) return 8'd0;
    q = acc >>> 8;
    f = acc & 255;
    if (f > 128 || (f == 128 && q % 2 == 1)) q++;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  // result word for the current output position, then step the position
  function automatic void emit_pixel(bit aligned);
    int unsigned ew, eh;
    bit border;
    out_word_t res;
    ew = eff_width();
    eh = eff_height();
    border = row_out == 0 || row_out == eh - 1 || col_out == 0 || col_out == ew - 1;
    if (border || !aligned) res.pixel_out = line_mem[(row_out % 2) * MAX_W + col_out];
    else res.pixel_out = filter_center();
    res.frame_end = (row_out == eh - 1 && col_out == ew - 1);
    pixels_due.push_back(res);
    if (res.frame_end) begin
      restart_frame();
    end else begin
      col_out++;
      if (col_out >= ew) begin
        col_out = 0;
        row_out++;
      end
    end
  endfunction

  // one accepted input word through the line stores and window
  function automatic void absorb_word(in_word_t w);
    int unsigned ew, eh, r, c, i;
    logic [7:0] col_px [0:2];
    ew = eff_width();
    eh = eff_height();
    if (w.action == ACT_DRAIN) begin
      if (row_in >= eh) emit_pixel(1'b0);
      return;
    end
    if (row_in >= eh) return;
    r = row_in;
    c = col_in;
    col_px[0] = line_mem[(r % 2) * MAX_W + c];
    col_px[1] = line_mem[((r + 1) % 2) * MAX_W + c];
    col_px[2] = w.pixel_in;
    line_mem[(r % 2) * MAX_W + c] = w.pixel_in;
    for (i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
      win[i][2] = col_px[i];
    end
    col_in++;
    if (col_in >= ew) begin
      col_in = 0;
      row_in++;
    end
    if (r >= 1 && (c >= 1 || r >= 2)) emit_pixel(c >= 1);
  endfunction

  // handshakes seen at the rising edge: results first, then input words
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pixels_due.size() == 0) begin
          flag_error($sformatf("word with nothing due: pixel_out %0d frame_end %0d",
                               out_word.pixel_out, out_word.frame_end));
        end else begin
          due_word = pixels_due.pop_front();
          if (out_word.pixel_out !== due_word.pixel_out)
            flag_error($sformatf("pixel_out expected %0d got %0d",
                                 due_word.pixel_out, out_word.pixel_out));
          if (out_word.frame_end !== due_word.frame_end)
            flag_error($sformatf("frame_end expected %0d got %0d",
                                 due_word.frame_end, out_word.frame_end));
        end
      end
      if (in_valid && !in_stall) begin
        absorb_word(in_word);
        word_taken = 1'b1;
      end
    end
  end

  // input word driver: hold a stalled word, else offer the next or idle
  always @(negedge clk) begin
    if (!in_valid || word_taken) begin
      if (rst_n && words_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_word <= words_to_send.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    word_taken = 1'b0;
  end

  // result stall driver
  always @(negedge clk) begin
    out_stall <= hold_on || ($urandom_range(0, 99) < recv_stall_pct);
  end

  // long receiver hold-off, counted here
  initial begin
    forever begin
      while (hold_len == 0) @(posedge clk);
      hold_on = 1'b1;
      repeat (hold_len) @(posedge clk);
      hold_on = 1'b0;
      hold_len = 0;
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void push_word(bit act, logic [7:0] px);
    in_word_t w;
    w.action = act;
    w.pixel_in = px;
    words_to_send.push_back(w);
  endfunction

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [47:0] random_kernel_row(int unsigned style);
    logic [47:0] row;
    int unsigned k;
    for (k = 0; k < 3; k++) begin
      case (style)
        0: row[16*k +: 16] = 16'($urandom);
        1: row[16*k +: 16] = 16'($urandom_range(0, 640)) - 16'd320;
        2: row[16*k +: 16] = STEP_COEFS[$urandom_range(0, 6)];
        default: row[16*k +: 16] = 16'h001C;
      endcase
    end
    return row;
  endfunction

  task automatic wait_words_taken();
    while (words_to_send.size() != 0 || in_valid) @(posedge clk);
  endtask

  // block idle: every word in, every result out, pipeline empty
  task automatic settle();
    wait_words_taken();
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_COEF_TOP: kern[0] = data;
      CFG_COEF_MID: kern[1] = data;
      CFG_COEF_BOT: kern[2] = data;
      CFG_WIDTH: begin
        reg_width = data[SIZE_W-1:0];
        restart_frame();
      end
      CFG_HEIGHT: begin
        reg_height = data[SIZE_W-1:0];
        restart_frame();
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // kernel and frame size, upper data bits sometimes junk
  task automatic load_setup(logic [47:0] top, logic [47:0] mid, logic [47:0] bot,
                            logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
    logic [CFG_DATA_W-SIZE_W-1:0] junk;
    settle();
    write_reg(CFG_COEF_TOP, top);
    write_reg(CFG_COEF_MID, mid);
    write_reg(CFG_COEF_BOT, bot);
    junk = $urandom_range(0, 1) ? {4'($urandom), $urandom()} : '0;
    write_reg(CFG_WIDTH, {junk, w});
    junk = $urandom_range(0, 1) ? {4'($urandom), $urandom()} : '0;
    write_reg(CFG_HEIGHT, {junk, h});
    frame_cut = 1'b0;
  endtask

  // 5x3 frame: half-to-even up, negative sum, saturation, ignored words
  task automatic test_directed_frame();
    logic [7:0] px [15] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
                            8'd0, 8'd5, 8'd1, 8'd255, 8'd7,
                            8'd255, 8'd255, 8'd0, 8'd0, 8'd255};
    int unsigned i;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    load_setup(48'h0, {16'h0000, 16'h0180, 16'hFE00}, 48'h0, 12'd5, 12'd3);
    for (i = 0; i < 15; i++) begin
      if (i == 3) push_word(ACT_DRAIN, 8'hFF);
      push_word(ACT_PIXEL, px[i]);
    end
    push_word(ACT_PIXEL, 8'hA5);
    for (i = 0; i < 6; i++) push_word(ACT_DRAIN, 8'h00);
    push_word(ACT_DRAIN, 8'h5A);
    settle();
  endtask

  // one random frame, sometimes cut short, with stray words mixed in
  task automatic random_frame(output int unsigned n_items);
    int unsigned ew, eh, n, i, style;
    logic [SIZE_W-1:0] w, h;
    bit cut;
    if (frame_cut || $urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 9))
        0: w = SIZE_W'($urandom_range(0, 2));
        1: w = SIZE_W'($urandom_range(13, 70));
        default: w = SIZE_W'($urandom_range(3, 12));
      endcase
      case ($urandom_range(0, 9))
        0: h = SIZE_W'($urandom_range(0, 2));
        1: h = SIZE_W'($urandom_range(7, 12));
        default: h = SIZE_W'($urandom_range(3, 6));
      endcase
      style = $urandom_range(0, 3);
      load_setup(random_kernel_row(style), random_kernel_row(style),
                 random_kernel_row(style), w, h);
    end
    ew = eff_width();
    eh = eff_height();
    cut = ($urandom_range(0, 9) == 0);
    n = cut ? $urandom_range(1, ew * eh - 1) : ew * eh;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) push_word(ACT_DRAIN, 8'($urandom));
      push_word(ACT_PIXEL, pick_pixel());
    end
    n_items = n;
    if (!cut) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) push_word(ACT_PIXEL, pick_pixel());
      for (i = 0; i <= ew; i++) push_word(ACT_DRAIN, 8'($urandom));
      n_items += ew + 1;
      if ($urandom_range(0, 3) == 0) push_word(ACT_DRAIN, 8'($urandom));
    end
    frame_cut = cut;
  endtask

  task automatic test_random_frames(int unsigned idle_pct, int unsigned stall_pct);
    int unsigned total, n;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    total = 0;
    while (total < 300) begin
      random_frame(n);
      total += n;
    end
    wait_words_taken();
  endtask

  // receiver holds off until the block stalls its input, then a paused sender
  task automatic test_backpressure();
    int unsigned i;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    load_setup(random_kernel_row(1), random_kernel_row(1), random_kernel_row(1),
               12'd8, 12'd6);
    hold_len = 150;
    for (i = 0; i < 48; i++) push_word(ACT_PIXEL, pick_pixel());
    for (i = 0; i < 9; i++) push_word(ACT_DRAIN, 8'h00);
    wait_words_taken();
    for (i = 0; i < 20; i++) push_word(ACT_PIXEL, pick_pixel());
    wait_words_taken();
    while (pixels_due.size() != 0) @(posedge clk);
    for (i = 0; i < 28; i++) push_word(ACT_PIXEL, pick_pixel());
    for (i = 0; i < 9; i++) push_word(ACT_DRAIN, 8'h00);
    settle();
  endtask

  // tallest and widest frame sizes, the tallest cut short after its first rows, the widest within its first row
  task automatic test_frame_sizes();
    int unsigned i;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    load_setup(random_kernel_row(1), random_kernel_row(2), random_kernel_row(1),
               12'd0, 12'd4095);
    for (i = 0; i < 3 * 30; i++) push_word(ACT_PIXEL, pick_pixel());
    for (i = 0; i < 4; i++) push_word(ACT_DRAIN, 8'h00);
    frame_cut = 1'b1;
    load_setup(random_kernel_row(0), random_kernel_row(0), random_kernel_row(0),
               12'd4095, 12'd4095);
    for (i = 0; i < 200; i++) push_word(ACT_PIXEL, pick_pixel());
    frame_cut = 1'b1;
    settle();
  endtask

  initial begin
    int unsigned k;
    // bench filter starts from the reset state
    for (k = 0; k < 2 * MAX_W; k++) line_mem[k] = 8'd0;
    for (k = 0; k < 9; k++) win[k / 3][k % 3] = 8'd0;
    for (k = 0; k < 3; k++) kern[k] = 48'd0;
    reg_width = WIDTH_RST;
    reg_height = HEIGHT_RST;
    restart_frame();

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_frame();
    test_random_frames(0, 0);
    test_random_frames(63, 0);
    test_random_frames(0, 63);
    test_random_frames(34, 34);
    test_backpressure();
    test_frame_sizes();
    settle();

    if (bad_words == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
